// ----- rtl/core/i2cm_pkg.sv -----
package i2cm_pkg;

   localparam int TIMEOUT_BITS_DEF = 16;
   localparam int TIMEOUT_MAX_BITS = 16;
   localparam int ACK_TIMEOUT_BITS = 15;
   localparam logic [ACK_TIMEOUT_BITS-1:0] ACK_TIMEOUT_RESET = 15'd255;
   localparam logic [2:0] LAST_BIT = 3'd7;
   localparam int QUEUE_DEPTH = 2;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic REG_ACK_TIMEOUT = 1'b0;

   typedef enum logic [2:0] {
      CMD_IDLE  = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_WRITE = 3'd3,
      CMD_READ  = 3'd4,
      CMD_WAIT  = 3'd5
   } cmd_type;

   // Wait ack reuses the first three: wait for low, clock high, clock low.
   typedef enum logic [2:0] {
      PH_SETUP       = 3'd0,
      PH_CLOCK       = 3'd1,
      PH_ACK_SETUP   = 3'd2,
      PH_ACK_CLOCK   = 3'd3,
      PH_ACK_RELEASE = 3'd4,
      PH_NACK_CLOCK  = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_TIMEOUT  = 2'd1,
      ST_UNSTABLE = 2'd2,
      ST_BUSY     = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] data_byte;
      logic       send_ack;
      logic       sda_in;
   } entry_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [1:0] status;
      logic [7:0] read_byte;
   } rsp_word_type;

endpackage

// ----- rtl/core/i2cm_if.sv -----
interface i2cm_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] req_type;
   logic [7:0] data_byte;
   logic       send_ack;
   logic       sda_in;

   modport source (output valid, req_type, data_byte, send_ack, sda_in, input ready);
   modport sink (input valid, req_type, data_byte, send_ack, sda_in, output ready);
endinterface

interface i2cm_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_out;
   logic       sda_out;
   logic       busy_res;
   logic       done_res;
   logic [1:0] status;
   logic [7:0] read_byte;

   modport source (output valid, scl_out, sda_out, busy_res, done_res, status, read_byte,
                   input ready);
   modport sink (input valid, scl_out, sda_out, busy_res, done_res, status, read_byte,
                 output ready);
endinterface

// ----- rtl/core/i2cm_front.sv -----
module i2cm_front
   import i2cm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   i2cm_req_if.sink    req,
   output logic        out_valid,
   input  logic        out_ready,
   output entry_type   out_entry
);

   logic      valid_ff, valid_in;
   entry_type entry_ff, entry_in;
   cmd_type   cmd;

   assign req.ready = !valid_ff || out_ready;

   always_comb begin
      unique case (req.req_type)
         CMD_START: cmd = CMD_START;
         CMD_STOP:  cmd = CMD_STOP;
         CMD_WRITE: cmd = CMD_WRITE;
         CMD_READ:  cmd = CMD_READ;
         CMD_WAIT:  cmd = CMD_WAIT;
         default: cmd = CMD_IDLE;   // tick and unused codes
      endcase
      entry_in.cmd       = cmd;
      entry_in.data_byte = req.data_byte;
      entry_in.send_ack  = req.send_ack;
      entry_in.sda_in    = req.sda_in;
      valid_in = valid_ff;
      if (req.ready) begin
         valid_in = req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req.valid && req.ready) begin
         entry_ff <= entry_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_entry = entry_ff;

endmodule

// ----- rtl/core/i2cm_queue.sv -----
module i2cm_queue
   import i2cm_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  entry_type in_entry,
   output logic      out_valid,
   input  logic      out_ready,
   output entry_type out_entry
);

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   entry_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                push, pop;

   assign in_ready  = count_ff < CNT_BITS'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_entry = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_entry;
      end
   end

endmodule

// ----- rtl/core/i2cm_back.sv -----
module i2cm_back
   import i2cm_pkg::*;
#(
   parameter int TIMEOUT_BITS = TIMEOUT_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [ACK_TIMEOUT_BITS-1:0] ack_timeout,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  entry_type                   in_entry,
   i2cm_rsp_if.source                  rsp
);

   localparam logic [TIMEOUT_MAX_BITS-1:0] TIMEOUT_LIM =
      TIMEOUT_MAX_BITS'((32'd1 << TIMEOUT_BITS) - 32'd1);

   cmd_type               act_ff, act_in;
   phase_type             phase_ff, phase_in;
   logic [2:0]            bidx_ff, bidx_in;
   logic [7:0]            shift_ff, shift_in;
   logic [TIMEOUT_BITS-1:0] tleft_ff, tleft_in;
   logic                  ackc_ff, ackc_in;
   logic                  scl_ff, scl_in;
   logic                  sda_ff, sda_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          word_ff, word;

   logic [TIMEOUT_MAX_BITS-1:0] ato_ext, tload;
   logic                  fire, finish, rejected, post_scl, post_sda;

   assign in_ready = !rsp_valid_ff || rsp.ready;
   assign fire     = in_valid && in_ready;
   assign ato_ext  = TIMEOUT_MAX_BITS'(ack_timeout);
   assign tload    = (ato_ext > TIMEOUT_LIM) ? TIMEOUT_LIM : ato_ext;

   always_comb begin
      act_in   = act_ff;
      phase_in = phase_ff;
      bidx_in  = bidx_ff;
      shift_in = shift_ff;
      tleft_in = tleft_ff;
      ackc_in  = ackc_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      word     = '0;
      finish   = 1'b0;
      rejected = 1'b0;
      post_scl = 1'b0;
      post_sda = 1'b0;

      if (in_entry.cmd != CMD_IDLE) begin
         if (act_ff != CMD_IDLE) begin
            rejected = 1'b1;
         end else begin
            act_in   = in_entry.cmd;
            phase_in = PH_SETUP;
            bidx_in  = LAST_BIT;
            shift_in = (in_entry.cmd == CMD_WRITE) ? in_entry.data_byte : 8'd0;
            ackc_in  = in_entry.send_ack;
            tleft_in = tload[TIMEOUT_BITS-1:0];
         end
      end

      if (act_in != CMD_IDLE) begin
         word.busy_res = 1'b1;
         post_scl = scl_ff;
         post_sda = sda_ff;
         unique case (act_in)
            CMD_START: begin
               if (phase_in == PH_SETUP) begin
                  scl_in   = 1'b1;
                  sda_in   = 1'b1;
                  phase_in = PH_CLOCK;
               end else begin
                  scl_in   = 1'b1;
                  sda_in   = 1'b0;
                  finish   = 1'b1;
                  post_scl = 1'b0;
                  post_sda = 1'b0;
               end
            end
            CMD_STOP: begin
               scl_in   = 1'b1;
               sda_in   = 1'b0;
               finish   = 1'b1;
               post_scl = 1'b1;
               post_sda = 1'b1;
            end
            CMD_WRITE: begin
               sda_in = shift_in[bidx_in];
               if (phase_in == PH_SETUP) begin
                  scl_in   = 1'b0;
                  phase_in = PH_CLOCK;
               end else begin
                  scl_in = 1'b1;
                  if (bidx_in == 3'd0) begin
                     finish   = 1'b1;
                     post_scl = 1'b0;
                     post_sda = 1'b1;
                  end else begin
                     bidx_in  = bidx_in - 3'd1;
                     phase_in = PH_SETUP;
                  end
               end
            end
            CMD_READ: begin
               unique case (phase_in)
                  PH_SETUP: begin
                     scl_in   = 1'b0;
                     phase_in = PH_CLOCK;
                  end
                  PH_CLOCK: begin
                     scl_in   = 1'b1;
                     shift_in = {shift_in[6:0], in_entry.sda_in};
                     if (bidx_in == 3'd0) begin
                        phase_in = PH_ACK_SETUP;
                     end else begin
                        bidx_in  = bidx_in - 3'd1;
                        phase_in = PH_SETUP;
                     end
                  end
                  PH_ACK_SETUP: begin
                     scl_in   = 1'b0;
                     phase_in = ackc_in ? PH_ACK_CLOCK : PH_NACK_CLOCK;
                  end
                  PH_ACK_CLOCK: begin
                     scl_in   = 1'b1;
                     sda_in   = 1'b0;
                     phase_in = PH_ACK_RELEASE;
                  end
                  default: begin
                     // release after ACK, or clock the NACK with SDA high
                     scl_in         = (phase_in != PH_ACK_RELEASE);
                     sda_in         = 1'b1;
                     finish         = 1'b1;
                     post_scl       = 1'b0;
                     post_sda       = 1'b1;
                     word.read_byte = shift_in;
                  end
               endcase
            end
            CMD_WAIT: begin
               unique case (phase_in)
                  PH_SETUP: begin
                     if (tleft_in == '0) begin
                        finish      = 1'b1;
                        word.status = ST_TIMEOUT;
                     end else begin
                        tleft_in = tleft_in - 1'b1;
                        if (!in_entry.sda_in) begin
                           phase_in = PH_CLOCK;
                        end
                     end
                  end
                  PH_CLOCK: begin
                     scl_in   = 1'b1;
                     post_scl = 1'b1;
                     post_sda = sda_in;
                     if (in_entry.sda_in) begin
                        finish      = 1'b1;
                        word.status = ST_UNSTABLE;
                     end else begin
                        phase_in = PH_ACK_SETUP;
                     end
                  end
                  default: begin
                     scl_in   = 1'b0;
                     finish   = 1'b1;
                     post_scl = 1'b0;
                     post_sda = sda_in;
                  end
               endcase
            end
            default: ;
         endcase
      end

      word.scl_out = scl_in;
      word.sda_out = sda_in;

      if (finish) begin
         word.done_res = 1'b1;
         scl_in   = post_scl;
         sda_in   = post_sda;
         act_in   = CMD_IDLE;
         phase_in = PH_SETUP;
         bidx_in  = LAST_BIT;
      end
      if (rejected) begin
         word.status = ST_BUSY;
      end

      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff       <= CMD_IDLE;
         phase_ff     <= PH_SETUP;
         bidx_ff      <= LAST_BIT;
         shift_ff     <= '0;
         tleft_ff     <= '0;
         ackc_ff      <= 1'b0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            act_ff   <= act_in;
            phase_ff <= phase_in;
            bidx_ff  <= bidx_in;
            shift_ff <= shift_in;
            tleft_ff <= tleft_in;
            ackc_ff  <= ackc_in;
            scl_ff   <= scl_in;
            sda_ff   <= sda_in;
         end
      end
      if (fire) begin
         word_ff <= word;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.scl_out   = word_ff.scl_out;
   assign rsp.sda_out   = word_ff.sda_out;
   assign rsp.busy_res  = word_ff.busy_res;
   assign rsp.done_res  = word_ff.done_res;
   assign rsp.status    = word_ff.status;
   assign rsp.read_byte = word_ff.read_byte;

endmodule

// ----- rtl/core/i2c_master_byte_engine.sv -----
// channel | dir | handshake     | word
// req     | in  | valid/ready   | req_type, data_byte, send_ack, sda_in (one bus slot)
// rsp     | out | valid/ready   | scl_out, sda_out, busy_res, done_res, status, read_byte
// csr     | in  | APB, pready=1 | ack_timeout at byte address 0
//
// One word per clock sustained while rsp is not stalled; the back end executes one
// bus slot per cycle while it accepts words. A word accepted on req passes the
// classify register, two-entry queue and result register before rsp shows it valid.
// Synchronous active-high reset; no clearing pass. Either side may stall
// independently, the queue and result register absorb the difference.
module i2c_master_byte_engine
   import i2cm_pkg::*;
#(
   parameter int TIMEOUT_BITS = TIMEOUT_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   i2cm_req_if.sink                 req,
   i2cm_rsp_if.source               rsp,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   logic [ACK_TIMEOUT_BITS-1:0] ato_ff;
   logic                        f_valid, f_ready, q_valid, q_ready;
   entry_type                   f_entry, q_entry;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_ACK_TIMEOUT) ? CSR_DATA_BITS'(ato_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         ato_ff <= ACK_TIMEOUT_RESET;
      end else if (psel && penable && pwrite && (paddr[2] == REG_ACK_TIMEOUT)) begin
         ato_ff <= pwdata[ACK_TIMEOUT_BITS-1:0];
      end
   end

   i2cm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_entry (f_entry)
   );

   i2cm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_entry  (f_entry),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_entry (q_entry)
   );

   i2cm_back #(
      .TIMEOUT_BITS (TIMEOUT_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .ack_timeout (ato_ff),
      .in_valid    (q_valid),
      .in_ready    (q_ready),
      .in_entry    (q_entry),
      .rsp         (rsp)
   );

endmodule
